### src/jdf_pkg.sv
// Package for the joinable dual FIFO: command, mode and register codes,
// controller state type and the controller-to-datapath command struct.
// No dependencies.
package jdf_pkg;

  // Default sizes handed to the top level parameters
  localparam int DEF_STORE_DEPTH = 8;
  localparam int DEF_WORD_WIDTH  = 32;

  // Field widths fixed by the interface
  localparam int CMD_W      = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // Command codes carried on in_tuser
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;  // enqueue to TX
  localparam logic [CMD_W-1:0] CMD_PULL  = 2'd1;  // dequeue from TX
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd2;  // enqueue to RX
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;  // dequeue from RX

  // FIFO mode codes; the unused code behaves as bidirectional
  localparam logic [MODE_W-1:0] MODE_BIDI    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RX_ONLY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TX_ONLY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIFO_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_SEL = 2'd1;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_HOLD
  } jdf_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;    // perform the command of the beat accepted now
    logic cfg_wr;  // take the configuration beat accepted now
  } jdf_cmd_t;

endpackage

### src/joinable_dual_fifo_top.sv
// Top level of the joinable dual FIFO: stream ports, field packing and the
// controller and datapath. Depends on jdf_pkg, jdf_ctrl and jdf_dp.
//
//  channel  direction  handshake               payload
//  in_      slave      in_tvalid / in_tready   tuser: command; tdata: data_in
//  out_     master     out_tvalid / out_tready tuser: accepted;
//                                              tdata: data_out, status, levels
//  cfg_     slave      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each command is performed at the accept edge, which also registers the store
// read; the next cycle presents the result, which then holds until
// out_tready. One beat is in flight at a time.
// Synchronous active-low reset empties both FIFOs, selects bidirectional
// mode and RX status; the word store itself is not cleared.
// Configuration beats are taken only while idle with no input beat offered.
module joinable_dual_fifo_top
  import jdf_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int WORD_WIDTH  = DEF_WORD_WIDTH,
  parameter int CNT_W       = $clog2(STORE_DEPTH + 1),
  parameter int IN_TD_W     = ((WORD_WIDTH + 7) / 8) * 8,
  parameter int OUT_TD_W    = ((2 * WORD_WIDTH + 2 * CNT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TD_W-1:0]    in_tdata,   // data_in
  input  logic [CMD_W-1:0]      in_tuser,   // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_TD_W-1:0]   out_tdata,  // data_out, status_word, rx_level, tx_level
  output logic                  out_tuser,  // accepted
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  jdf_cmd_t              cmd;
  logic [WORD_WIDTH-1:0] data_out, status_word;
  logic [CNT_W-1:0]      rx_level, tx_level;

  jdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  jdf_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_command  (in_tuser),
    .in_data     (in_tdata[WORD_WIDTH-1:0]),
    .cfg_index   (cfg_index),
    .cfg_value   (cfg_data),
    .accepted    (out_tuser),
    .data_out    (data_out),
    .status_word (status_word),
    .rx_level    (rx_level),
    .tx_level    (tx_level)
  );

  // Pack the result fields, lowest first, zero-filled to whole bytes
  assign out_tdata = OUT_TD_W'({tx_level, rx_level, status_word, data_out});

endmodule

### src/jdf_ctrl.sv
// Controller of the joinable dual FIFO: sequences accept, execute and
// result hand-off. Depends on jdf_pkg.
module jdf_ctrl
  import jdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output jdf_cmd_t cmd
);

  jdf_state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance: accept one beat, then hold the result until it is taken
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Drive handshakes and datapath commands; an input beat wins over config
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cfg_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cfg_ready = !in_valid;
      end
      S_HOLD: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.exec   = in_valid && in_ready;
    cmd.cfg_wr = cfg_valid && cfg_ready;
  end

`ifndef SYNTHESIS
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (out_valid && !in_ready))
    else $error("accepted beat did not lead to a held result");

  a_taken_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (in_ready && !out_valid))
    else $error("controller did not return to idle after result taken");

  a_exec_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && cmd.cfg_wr))
    else $error("command and configuration beat taken together");
`endif

endmodule

### src/jdf_dp.sv
// Datapath of the joinable dual FIFO: shared word store, per-FIFO head
// offsets and counts, configuration registers and result registers.
// Depends on jdf_pkg.
module jdf_dp
  import jdf_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int WORD_WIDTH  = DEF_WORD_WIDTH,
  parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  jdf_cmd_t              cmd,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [WORD_WIDTH-1:0] in_data,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_value,
  output logic                  accepted,
  output logic [WORD_WIDTH-1:0] data_out,
  output logic [WORD_WIDTH-1:0] status_word,
  output logic [CNT_W-1:0]      rx_level,
  output logic [CNT_W-1:0]      tx_level
);

  localparam int AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int HALF = STORE_DEPTH / 2;

  logic [WORD_WIDTH-1:0] mem [STORE_DEPTH];

  logic [MODE_W-1:0]     mode_r;
  logic                  sel_r;
  logic [CNT_W-1:0]      rx_cnt_r, tx_cnt_r;
  logic [AW-1:0]         rx_head_r, tx_head_r;
  logic [WORD_WIDTH-1:0] rd_data_r;
  logic                  ok_r, deq_r;

  logic                  joined, is_tx, is_enq, allowed, ok_c;
  logic [CNT_W-1:0]      cap_c, cnt_c, head_inc, level_c;
  logic [AW-1:0]         base_c, head_c, wr_off, head_nxt;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [CNT_W:0]        tail_sum;

  // Region layout and capacity from the mode
  always_comb begin
    joined = (mode_r == MODE_RX_ONLY) || (mode_r == MODE_TX_ONLY);
    cap_c  = joined ? CNT_W'(STORE_DEPTH) : CNT_W'(HALF);
    is_tx  = (in_command == CMD_WRITE) || (in_command == CMD_PULL);
    is_enq = (in_command == CMD_WRITE) || (in_command == CMD_PUSH);
    if (is_tx) begin
      allowed = (mode_r != MODE_RX_ONLY);
      cnt_c   = tx_cnt_r;
      head_c  = tx_head_r;
      base_c  = (mode_r == MODE_TX_ONLY) ? '0 : AW'(HALF);
    end else begin
      allowed = (mode_r != MODE_TX_ONLY);
      cnt_c   = rx_cnt_r;
      head_c  = rx_head_r;
      base_c  = '0;
    end
    ok_c = allowed && (is_enq ? (cnt_c < cap_c) : (cnt_c != '0));
  end

  // Tail and head addresses, wrapped within the region
  always_comb begin
    tail_sum = (CNT_W + 1)'(head_c) + (CNT_W + 1)'(cnt_c);
    if (tail_sum >= (CNT_W + 1)'(cap_c)) begin
      tail_sum = tail_sum - (CNT_W + 1)'(cap_c);
    end
    wr_off   = AW'(tail_sum);
    wr_addr  = base_c + wr_off;
    rd_addr  = base_c + head_c;
    head_inc = CNT_W'(head_c) + CNT_W'(1);
    head_nxt = (head_inc == cap_c) ? '0 : AW'(head_inc);
  end

  // Write and read the word store
  always_ff @(posedge clk) begin
    if (cmd.exec && ok_c && is_enq) begin
      mem[wr_addr] <= in_data;
    end
    if (cmd.exec && ok_c && !is_enq) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Update configuration, counts and heads; a register write clears both
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BIDI;
      sel_r     <= 1'b1;
      rx_cnt_r  <= '0;
      tx_cnt_r  <= '0;
      rx_head_r <= '0;
      tx_head_r <= '0;
      ok_r      <= 1'b0;
      deq_r     <= 1'b0;
    end else if (cmd.cfg_wr) begin
      if (cfg_index == REG_FIFO_MODE || cfg_index == REG_STATUS_SEL) begin
        if (cfg_index == REG_FIFO_MODE) begin
          mode_r <= cfg_value[MODE_W-1:0];
        end else begin
          sel_r <= cfg_value[0];
        end
        rx_cnt_r  <= '0;
        tx_cnt_r  <= '0;
        rx_head_r <= '0;
        tx_head_r <= '0;
      end
    end else if (cmd.exec) begin
      ok_r  <= ok_c;
      deq_r <= ok_c && !is_enq;
      if (ok_c) begin
        if (is_tx) begin
          tx_cnt_r <= is_enq ? tx_cnt_r + CNT_W'(1) : tx_cnt_r - CNT_W'(1);
          if (!is_enq) begin
            tx_head_r <= head_nxt;
          end
        end else begin
          rx_cnt_r <= is_enq ? rx_cnt_r + CNT_W'(1) : rx_cnt_r - CNT_W'(1);
          if (!is_enq) begin
            rx_head_r <= head_nxt;
          end
        end
      end
    end
  end

  // Form the result from the registered state
  always_comb begin
    level_c     = sel_r ? rx_cnt_r : tx_cnt_r;
    accepted    = ok_r;
    data_out    = deq_r ? rd_data_r : '0;
    status_word = (level_c < cap_c) ? '1 : '0;
    rx_level    = rx_cnt_r;
    tx_level    = tx_cnt_r;
  end

`ifndef SYNTHESIS
  a_cnt_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_cnt_r <= cap_c) && (tx_cnt_r <= cap_c))
    else $error("FIFO count beyond region capacity");

  a_rx_only_tx_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_RX_ONLY) |-> (tx_cnt_r == '0))
    else $error("TX FIFO holds words in receive-only mode");

  a_tx_only_rx_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_TX_ONLY) |-> (rx_cnt_r == '0))
    else $error("RX FIFO holds words in transmit-only mode");

  a_reject_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !ok_c) |=> ($stable(rx_cnt_r) && $stable(tx_cnt_r) &&
                             $stable(rx_head_r) && $stable(tx_head_r)))
    else $error("rejected command changed FIFO state");
`endif

endmodule
